// ===== rtl/core/framed_time_sync_parser_core_assert.svh =====
// Assertion macros shared by the framed time-sync parser RTL.
`ifndef FRAMED_TIME_SYNC_PARSER_CORE_ASSERT_SVH
`define FRAMED_TIME_SYNC_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FTSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ftsp_pkg.sv =====
// Types and constants of the framed time-sync parser.
package ftsp_pkg;

    localparam int unsigned SYNC_LEN = 7;
    localparam int unsigned CFG_AW   = 8;

    localparam logic [7:0] LIMIT_CAP = 8'd250;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_START_MARKER = 8'd0;
    localparam logic [CFG_AW-1:0] REG_END_MARKER   = 8'd1;
    localparam logic [CFG_AW-1:0] REG_SYNC_CMD     = 8'd2;
    localparam logic [CFG_AW-1:0] REG_MAX_LEN      = 8'd3;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_START_MARKER = 8'd2;
    localparam logic [7:0] RST_END_MARKER   = 8'd3;
    localparam logic [7:0] RST_SYNC_CMD     = 8'd1;
    localparam logic [7:0] RST_MAX_LEN      = 8'd123;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] time_sync_command;
        logic [7:0] max_payload_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
    } t_time;

    // Parser status toward the handshake logic
    typedef struct packed {
        logic at_end;  // next beat is the end-marker slot of a frame
        logic hit;     // this beat closes a good time-sync frame
    } t_prs_stat;

endpackage

// ===== rtl/core/ftsp_parser.sv =====
// Frame parser: position counter, running XOR and payload capture.
`include "framed_time_sync_parser_core_assert.svh"

module ftsp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,
    input  logic [7:0]         i_rx_byte,
    input  ftsp_pkg::t_cfg     i_cfg,
    output ftsp_pkg::t_prs_stat o_stat,
    output ftsp_pkg::t_time    o_time
);
    import ftsp_pkg::*;

    logic [7:0] r_pos;
    logic [7:0] r_len;
    logic [7:0] r_chk;
    logic [7:0] r_cmd;
    logic [7:0] r_rchk;
    logic [7:0] r_payload [SYNC_LEN];

    logic [7:0] n_pos;
    logic [7:0] n_len;
    logic [7:0] n_chk;
    logic [7:0] n_cmd;
    logic [7:0] n_rchk;

    logic [7:0] w_limit;
    logic [8:0] w_chk_pos;
    logic       w_in_payload;
    logic       w_at_chk;
    logic       w_at_end;
    logic [7:0] w_k;
    logic       w_cap;
    logic       w_good;

    assign w_limit      = (i_cfg.max_payload_len > LIMIT_CAP) ? LIMIT_CAP
                                                               : i_cfg.max_payload_len;
    assign w_chk_pos    = {1'b0, r_len} + 9'd3;
    assign w_in_payload = (r_pos >= 8'd3) && ({1'b0, r_pos} < w_chk_pos);
    assign w_at_chk     = ({1'b0, r_pos} == w_chk_pos);
    assign w_at_end     = (r_pos >= 8'd3) && !w_in_payload && !w_at_chk;
    assign w_k          = r_pos - 8'd3;
    assign w_cap        = i_beat && w_in_payload && (w_k < 8'(SYNC_LEN));

    assign w_good = (i_rx_byte == i_cfg.end_marker) && (r_chk == r_rchk) &&
                    (r_cmd == i_cfg.time_sync_command) && (r_len == 8'(SYNC_LEN));

    always_comb begin
        n_pos  = r_pos;
        n_len  = r_len;
        n_chk  = r_chk;
        n_cmd  = r_cmd;
        n_rchk = r_rchk;
        if (r_pos == 8'd0) begin
            if (i_rx_byte == i_cfg.start_marker) begin
                n_pos = 8'd1;
            end
        end else if (r_pos == 8'd1) begin
            n_cmd = i_rx_byte;
            n_chk = i_rx_byte;
            n_pos = 8'd2;
        end else if (r_pos == 8'd2) begin
            if (i_rx_byte > w_limit) begin
                n_pos = 8'd0;
                n_len = 8'd0;
            end else begin
                n_len = i_rx_byte;
                n_chk = r_chk ^ i_rx_byte;
                n_pos = 8'd3;
            end
        end else if (w_in_payload) begin
            n_chk = r_chk ^ i_rx_byte;
            n_pos = r_pos + 8'd1;
        end else if (w_at_chk) begin
            n_rchk = i_rx_byte;
            n_pos  = r_pos + 8'd1;
        end else begin
            n_pos = 8'd0;
            n_len = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 8'd0;
            r_len  <= 8'd0;
            r_chk  <= 8'd0;
            r_cmd  <= 8'd0;
            r_rchk <= 8'd0;
        end else if (i_beat) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_chk  <= n_chk;
            r_cmd  <= n_cmd;
            r_rchk <= n_rchk;
        end
    end

    // Only the first seven payload bytes are kept
    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_payload[w_k[2:0]] <= i_rx_byte;
        end
    end

    assign o_stat.at_end = w_at_end;
    assign o_stat.hit    = i_beat && w_at_end && w_good;

    assign o_time.hour   = r_payload[0];
    assign o_time.minute = r_payload[1];
    assign o_time.second = r_payload[2];
    assign o_time.year   = {r_payload[3], r_payload[4]};
    assign o_time.month  = r_payload[5];
    assign o_time.day    = r_payload[6];

    `FTSP_ASSERT_IMP(a_len_capped, i_clk, i_rst_n, 1'b1, r_len <= LIMIT_CAP,
                     "frame length above cap")
    `FTSP_ASSERT_IMP(a_hunt_len_zero, i_clk, i_rst_n, r_pos < 8'd3, r_len == 8'd0,
                     "length not cleared before payload phase")
    `FTSP_ASSERT_NXT(a_end_back_hunt, i_clk, i_rst_n, i_beat && w_at_end, r_pos == 8'd0,
                     "end slot did not return to hunting")

endmodule

// ===== rtl/core/framed_time_sync_parser_core.sv =====
// Top level of the framed time-sync parser: config registers, handshakes, result register.
//
// Input channel: one received byte per beat on i_rx_byte, qualified by i_valid,
// held off by o_stall. Frames are START, CMD, LEN, LEN payload bytes, CHK, END;
// the XOR of CMD, LEN and payload must match CHK. A good frame with the
// time-sync command and LEN of 7 yields one result beat; every other frame is
// dropped without a trace.
// Output channel: o_valid with the time fields, held off by i_stall.
// Throughput: one byte per cycle while o_stall is low. The parser state
// updates in the cycle a byte is taken; the result shows in the output register
// in the cycle after the end byte is accepted.
// Backpressure: bytes keep flowing while a result waits to be taken; only the
// end byte of a frame is held off (o_stall) while the output register is full
// and stalled, since that is the one byte that can produce a new result.
// Reset (synchronous, active low) restores the default markers, command and
// length limit, returns the parser to hunting and empties the output register.
// The user must make config writes while the block is idle; the block does not enforce it.
`include "framed_time_sync_parser_core_assert.svh"

module framed_time_sync_parser_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ftsp_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [7:0]                   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_hour,
    output logic [7:0]                   o_minute,
    output logic [7:0]                   o_second,
    output logic [15:0]                  o_year,
    output logic [7:0]                   o_month,
    output logic [7:0]                   o_day
);
    import ftsp_pkg::*;

    t_cfg       r_cfg;
    logic       r_out_valid;
    t_time      r_out;
    t_prs_stat  w_stat;
    t_time      w_time;
    logic       w_beat;
    logic       w_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker      <= RST_START_MARKER;
            r_cfg.end_marker        <= RST_END_MARKER;
            r_cfg.time_sync_command <= RST_SYNC_CMD;
            r_cfg.max_payload_len   <= RST_MAX_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_START_MARKER: r_cfg.start_marker      <= i_cfg_data;
                REG_END_MARKER:   r_cfg.end_marker        <= i_cfg_data;
                REG_SYNC_CMD:     r_cfg.time_sync_command <= i_cfg_data;
                REG_MAX_LEN:      r_cfg.max_payload_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_out_full = r_out_valid && i_stall;
    assign o_stall    = w_out_full && w_stat.at_end;
    assign w_beat     = i_valid && !o_stall;

    ftsp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (w_beat),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_stat    (w_stat),
        .o_time    (w_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.hit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.hit) begin
            r_out <= w_time;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_hour   = r_out.hour;
    assign o_minute = r_out.minute;
    assign o_second = r_out.second;
    assign o_year   = r_out.year;
    assign o_month  = r_out.month;
    assign o_day    = r_out.day;

    `FTSP_ASSERT_IMP(a_hit_needs_beat, i_clk, i_rst_n, w_stat.hit, w_beat,
                     "result raised without an input beat")
    `FTSP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_stat.hit, !w_out_full,
                     "pending result overwritten")
    `FTSP_ASSERT_IMP(a_rise_from_beat, i_clk, i_rst_n, $rose(r_out_valid), $past(w_beat),
                     "result appeared without an end beat")

endmodule
